@@ rtl/core/easc_pkg.sv @@
// Shared types and constants for the encoder angle, speed and current sense block.
// Holds the controller/datapath command and status structs and the fixed widths.
// No dependencies.
package easc_pkg;

	// Stream payload widths, padded to whole bytes.
	localparam int S_DATA_W = 112;
	localparam int M_DATA_W = 80;
	localparam int CFG_W    = 32;
	localparam int CFG_IX_W = 3;

	// Shared multiply-accumulate unit: 96-bit operand taken 32 bits per step.
	localparam int MAC_AW    = 96;
	localparam int MAC_BW    = 36;
	localparam int ACC_W     = MAC_AW + MAC_BW;
	localparam int MAC_STEPS = MAC_AW / 32;
	localparam int MAC_CNT_W = 2;

	// Shared restoring divider, one quotient bit per step.
	localparam int DIV_W     = 136;
	localparam int QUO_W     = 64;
	localparam int DIV_CNT_W = 6;
	localparam int DEN_W     = 88;

	// Current scaling: 3.3/4096 V per LSB is 33/40960, rounded half away from zero.
	// The division by 40960 = 8192 * 5 is a 13-bit shift followed by a multiply with
	// ceil(2^34 / 5), which gives the exact quotient by five for any 32-bit value.
	localparam logic [ACC_W-1:0]     CUR_ROUND  = ACC_W'(20480);
	localparam int                   CUR_SHIFT  = 13;
	localparam logic [MAC_BW-1:0]    DIV5_RECIP = 36'h0_CCCC_CCCD;
	localparam int                   DIV5_SHIFT = 34;
	localparam logic [DIV_CNT_W-1:0] ANG_STEPS  = DIV_CNT_W'(56);
	localparam logic [DIV_CNT_W-1:0] SPD_STEPS  = DIV_CNT_W'(32);

	// round(2*pi * 2^32)
	localparam logic [MAC_BW-1:0] TWO_PI_Q32 = 36'h6_487E_D511;

	typedef enum logic [CFG_IX_W-1:0] {
		CFG_CPR  = 3'd0,
		CFG_PP   = 3'd1,
		CFG_ENC  = 3'd2,
		CFG_TICK = 3'd3,
		CFG_GAIN = 3'd4,
		CFG_OFF  = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CUR_MUL,
		OP_CUR_DIV,
		OP_CUR_SAVE,
		OP_ANG_MUL,
		OP_ANG_DIV,
		OP_ANG_SAVE,
		OP_DEN_MUL,
		OP_DEN_SAVE,
		OP_SPD_MUL1,
		OP_SPD_MUL2,
		OP_SPD_MUL3,
		OP_SPD_DIV,
		OP_SPD_SAVE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load;
		logic hold_clr;
		logic spd_clr;
		logic last_upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic mac_done;
		logic div_done;
		logic busy;
		logic enc_on;
		logic count_ok;
		logic have_last;
		logic dt_zero;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/core/easc_mac.sv @@
// Shared multiply-accumulate unit: a 96-bit operand times a 36-bit operand,
// one 32-bit slice per cycle, most significant slice first.
// Depends on easc_pkg.
module easc_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [easc_pkg::MAC_AW-1:0] a,
	input  logic [easc_pkg::MAC_BW-1:0] b,
	output logic [easc_pkg::ACC_W-1:0]  acc,
	output logic                       busy,
	output logic                       done
);
	import easc_pkg::*;

	logic [MAC_AW-1:0]    a_q;
	logic [MAC_BW-1:0]    b_q;
	logic [ACC_W-1:0]     acc_q;
	logic [MAC_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [MAC_BW+31:0]   prod;

	assign prod = a_q[MAC_AW-1 -: 32] * b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == MAC_CNT_W'(1));
			if (start) begin
				cnt_q  <= MAC_CNT_W'(MAC_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - MAC_CNT_W'(1);
				if (cnt_q == MAC_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= {a_q[MAC_AW-33:0], 32'b0};
			acc_q <= {acc_q[ACC_W-33:0], 32'b0} + ACC_W'(prod);
		end
	end

	assign acc  = acc_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

@@ rtl/core/easc_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// The divisor arrives pre-shifted to align with the top quotient bit.
// Depends on easc_pkg.
module easc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [easc_pkg::DIV_W-1:0]     num,
	input  logic [easc_pkg::DIV_W-1:0]     den,
	input  logic [easc_pkg::DIV_CNT_W-1:0] steps,
	output logic [easc_pkg::QUO_W-1:0]     quo,
	output logic                          busy,
	output logic                          done
);
	import easc_pkg::*;

	logic [DIV_W-1:0]     r_q;
	logic [DIV_W-1:0]     d_q;
	logic [QUO_W-1:0]     q_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 ge;

	assign ge = (r_q >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				cnt_q  <= steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= num;
			d_q <= den;
			q_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				r_q <= r_q - d_q;
			end
			d_q <= {1'b0, d_q[DIV_W-1:1]};
			q_q <= {q_q[QUO_W-2:0], ge};
		end
	end

	assign quo  = q_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

@@ rtl/core/easc_dp.sv @@
// Datapath: configuration registers, captured item, held angle/speed state,
// operand selection for the shared multiplier and divider, and the output register.
// Depends on easc_pkg, easc_mac and easc_div.
module easc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [easc_pkg::CFG_IX_W-1:0]   cfg_index,
	input  logic [easc_pkg::CFG_W-1:0]      cfg_data,
	input  logic [easc_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [easc_pkg::M_DATA_W-1:0]   m_tdata,
	output logic [1:0]                     m_tuser,
	input  easc_pkg::cmd_t                  cmd,
	output easc_pkg::sts_t                  sts
);
	import easc_pkg::*;

	// Configuration
	logic [23:0] cpr_q;
	logic [7:0]  pp_q;
	logic        enc_q;
	logic [29:0] tick_q;
	logic [23:0] gain_q;
	logic [31:0] off_q;

	// Captured item and per-item values
	logic [11:0]      raw_q;
	logic [31:0]      cnt_q;
	logic [63:0]      ts_q;
	logic             ok_q;
	logic [63:0]      dt_q;
	logic             neg_q;
	logic [31:0]      mag_q;
	logic [DEN_W-1:0] den_q;
	logic [31:0]      cur_q;

	// Tick-to-tick state
	logic [31:0] last_count_q;
	logic [63:0] last_time_q;
	logic        have_last_q;
	logic [15:0] held_angle_q;
	logic        angle_valid_q;
	logic [31:0] held_speed_q;
	logic        speed_valid_q;

	// Output register
	logic                out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;
	logic [1:0]          out_user_q;

	// Shared units
	logic                 mac_start;
	logic [MAC_AW-1:0]    mac_a;
	logic [MAC_BW-1:0]    mac_b;
	logic [ACC_W-1:0]     acc;
	logic                 mac_busy;
	logic                 mac_done;
	logic                 div_start;
	logic [DIV_W-1:0]     div_num;
	logic [DIV_W-1:0]     div_den;
	logic [DIV_CNT_W-1:0] div_steps;
	logic [QUO_W-1:0]     quo;
	logic                 div_busy;
	logic                 div_done;

	logic [23:0]        cpr_eff;
	logic [23:0]        gain_mag;
	logic [17:0]        raw33;
	logic [31:0]        dcnt;
	logic [ACC_W-1:0]   cur_rnd;
	logic [24:0]        cur_mag;
	logic signed [33:0] cur_s;
	logic signed [33:0] cur_diff;
	logic [31:0]        cur_sat;
	logic [31:0]        spd_mag;
	logic [31:0]        spd_val;

	assign cpr_eff  = (cpr_q == '0) ? 24'd1 : cpr_q;
	assign gain_mag = gain_q[23] ? (24'd0 - gain_q) : gain_q;
	assign raw33    = {1'b0, raw_q, 5'b0} + {6'b0, raw_q};
	assign dcnt     = s_tdata[43:12] - last_count_q;

	// Rounded current magnitude: (product + 20480) / 40960, the quotient by five
	// coming out of the reciprocal multiply.
	assign cur_rnd  = acc + CUR_ROUND;
	assign cur_mag  = acc[DIV5_SHIFT+24:DIV5_SHIFT];

	// Signed current: apply the gain sign to the rounded magnitude, subtract the offset.
	assign cur_s    = gain_q[23] ? -$signed({9'b0, cur_mag}) : $signed({9'b0, cur_mag});
	assign cur_diff = cur_s - $signed({{2{off_q[31]}}, off_q});
	always_comb begin
		if (cur_diff[33:31] == 3'b000 || cur_diff[33:31] == 3'b111) begin
			cur_sat = cur_diff[31:0];
		end else if (cur_diff[33]) begin
			cur_sat = 32'h8000_0000;
		end else begin
			cur_sat = 32'h7FFF_FFFF;
		end
	end

	// The top quotient bit set means the magnitude reached 2^31 and the result clamps.
	assign spd_mag = {1'b0, quo[30:0]};
	always_comb begin
		if (quo[31]) begin
			spd_val = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			spd_val = neg_q ? (32'd0 - spd_mag) : spd_mag;
		end
	end

	always_comb begin
		mac_start = 1'b0;
		mac_a     = '0;
		mac_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_steps = '0;
		case (cmd.op)
			OP_CUR_MUL: begin
				mac_start = 1'b1;
				mac_a     = MAC_AW'(raw33);
				mac_b     = MAC_BW'(gain_mag);
			end
			OP_ANG_MUL: begin
				mac_start = 1'b1;
				mac_a     = MAC_AW'(cnt_q);
				mac_b     = MAC_BW'(pp_q);
			end
			OP_DEN_MUL: begin
				mac_start = 1'b1;
				mac_a     = MAC_AW'(dt_q);
				mac_b     = MAC_BW'(cpr_eff);
			end
			OP_SPD_MUL1: begin
				mac_start = 1'b1;
				mac_a     = MAC_AW'(mag_q);
				mac_b     = MAC_BW'(pp_q);
			end
			OP_SPD_MUL2: begin
				mac_start = 1'b1;
				mac_a     = acc[MAC_AW-1:0];
				mac_b     = MAC_BW'(tick_q);
			end
			OP_SPD_MUL3: begin
				mac_start = 1'b1;
				mac_a     = acc[MAC_AW-1:0];
				mac_b     = TWO_PI_Q32;
			end
			OP_CUR_DIV: begin
				// Divide by 40960 = 8192 * 5: drop 13 bits, then multiply by one fifth.
				mac_start = 1'b1;
				mac_a     = cur_rnd[MAC_AW+CUR_SHIFT-1:CUR_SHIFT];
				mac_b     = DIV5_RECIP;
			end
			OP_ANG_DIV: begin
				// Low 16 quotient bits of (count*pp << 16) / cpr are the angle fraction.
				div_start = 1'b1;
				div_num   = {acc[DIV_W-17:0], 16'b0};
				div_den   = DIV_W'({cpr_eff, 55'b0});
				div_steps = ANG_STEPS;
			end
			OP_SPD_DIV: begin
				div_start = 1'b1;
				div_num   = DIV_W'(acc);
				div_den   = DIV_W'({den_q, 47'b0});
				div_steps = SPD_STEPS;
			end
			default: begin
			end
		endcase
	end

	easc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc),
		.busy   (mac_busy),
		.done   (mac_done)
	);

	easc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.quo    (quo),
		.busy   (div_busy),
		.done   (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q         <= 24'd4096;
			pp_q          <= 8'd1;
			enc_q         <= 1'b0;
			tick_q        <= 30'd240000000;
			gain_q        <= 24'd65536;
			off_q         <= '0;
			last_count_q  <= '0;
			last_time_q   <= '0;
			have_last_q   <= 1'b0;
			held_angle_q  <= '0;
			angle_valid_q <= 1'b0;
			held_speed_q  <= '0;
			speed_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_CPR:  cpr_q  <= cfg_data[23:0];
					CFG_PP:   pp_q   <= cfg_data[7:0];
					CFG_ENC:  enc_q  <= cfg_data[0];
					CFG_TICK: tick_q <= cfg_data[29:0];
					CFG_GAIN: gain_q <= cfg_data[23:0];
					CFG_OFF:  off_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			case (cmd.op)
				OP_ANG_SAVE: begin
					held_angle_q  <= quo[15:0];
					angle_valid_q <= 1'b1;
				end
				OP_SPD_SAVE: begin
					held_speed_q  <= spd_val;
					speed_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
			if (cmd.hold_clr) begin
				held_angle_q  <= '0;
				angle_valid_q <= 1'b0;
				held_speed_q  <= '0;
				speed_valid_q <= 1'b0;
			end
			if (cmd.spd_clr) begin
				held_speed_q  <= '0;
				speed_valid_q <= 1'b0;
			end
			if (cmd.last_upd) begin
				last_count_q <= cnt_q;
				last_time_q  <= ts_q;
				have_last_q  <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q <= s_tdata[11:0];
			cnt_q <= s_tdata[43:12];
			ts_q  <= s_tdata[107:44];
			ok_q  <= s_tuser;
			dt_q  <= s_tdata[107:44] - last_time_q;
			neg_q <= dcnt[31];
			mag_q <= dcnt[31] ? (32'd0 - dcnt) : dcnt;
		end
		if (cmd.op == OP_CUR_SAVE) begin
			cur_q <= cur_sat;
		end
		if (cmd.op == OP_DEN_SAVE) begin
			den_q <= acc[DEN_W-1:0];
		end
		if (cmd.out_load) begin
			out_data_q <= {speed_valid_q ? held_speed_q : 32'd0,
				angle_valid_q ? held_angle_q : 16'd0, cur_q};
			out_user_q <= {speed_valid_q, angle_valid_q};
		end
	end

	always_comb begin
		sts.mac_done  = mac_done;
		sts.div_done  = div_done;
		sts.busy      = mac_busy | div_busy;
		sts.enc_on    = enc_q;
		sts.count_ok  = ok_q;
		sts.have_last = have_last_q;
		sts.dt_zero   = (dt_q == '0);
		sts.out_free  = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

@@ rtl/core/easc_ctrl.sv @@
// Controller: one-hot sequencer that steps one item through the shared
// multiplier and divider and decides which held values change.
// Depends on easc_pkg.
module easc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  easc_pkg::sts_t sts,
	output easc_pkg::cmd_t cmd
);
	import easc_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_CUR_MUL  = 11'b000_0000_0010,
		S_CUR_DIV  = 11'b000_0000_0100,
		S_ANG_MUL  = 11'b000_0000_1000,
		S_ANG_DIV  = 11'b000_0001_0000,
		S_DEN_MUL  = 11'b000_0010_0000,
		S_SPD_MUL1 = 11'b000_0100_0000,
		S_SPD_MUL2 = 11'b000_1000_0000,
		S_SPD_MUL3 = 11'b001_0000_0000,
		S_SPD_DIV  = 11'b010_0000_0000,
		S_OUT      = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   pend_q, pend_d;
	logic   can_go;

	// A step launches its unit once, then waits for that unit's done pulse.
	assign can_go   = !pend_q && !sts.busy;
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		cmd     = '0;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_CUR_MUL;
				end
			end
			S_CUR_MUL: begin
				if (can_go) begin
					cmd.op = OP_CUR_MUL;
					pend_d = 1'b1;
				end else if (pend_q && sts.mac_done) begin
					pend_d  = 1'b0;
					state_d = S_CUR_DIV;
				end
			end
			S_CUR_DIV: begin
				// The division by 40960 runs as a reciprocal multiply on the MAC.
				if (can_go) begin
					cmd.op = OP_CUR_DIV;
					pend_d = 1'b1;
				end else if (pend_q && sts.mac_done) begin
					pend_d = 1'b0;
					cmd.op = OP_CUR_SAVE;
					if (!sts.enc_on) begin
						cmd.hold_clr = 1'b1;
						state_d      = S_OUT;
					end else if (!sts.count_ok) begin
						state_d = S_OUT;
					end else begin
						state_d = S_ANG_MUL;
					end
				end
			end
			S_ANG_MUL: begin
				if (can_go) begin
					cmd.op = OP_ANG_MUL;
					pend_d = 1'b1;
				end else if (pend_q && sts.mac_done) begin
					pend_d  = 1'b0;
					state_d = S_ANG_DIV;
				end
			end
			S_ANG_DIV: begin
				if (can_go) begin
					cmd.op = OP_ANG_DIV;
					pend_d = 1'b1;
				end else if (pend_q && sts.div_done) begin
					pend_d = 1'b0;
					cmd.op = OP_ANG_SAVE;
					if (!sts.have_last) begin
						cmd.spd_clr  = 1'b1;
						cmd.last_upd = 1'b1;
						state_d      = S_OUT;
					end else if (sts.dt_zero) begin
						cmd.last_upd = 1'b1;
						state_d      = S_OUT;
					end else begin
						state_d = S_DEN_MUL;
					end
				end
			end
			S_DEN_MUL: begin
				if (can_go) begin
					cmd.op = OP_DEN_MUL;
					pend_d = 1'b1;
				end else if (pend_q && sts.mac_done) begin
					pend_d  = 1'b0;
					cmd.op  = OP_DEN_SAVE;
					state_d = S_SPD_MUL1;
				end
			end
			S_SPD_MUL1: begin
				if (can_go) begin
					cmd.op = OP_SPD_MUL1;
					pend_d = 1'b1;
				end else if (pend_q && sts.mac_done) begin
					pend_d  = 1'b0;
					state_d = S_SPD_MUL2;
				end
			end
			S_SPD_MUL2: begin
				if (can_go) begin
					cmd.op = OP_SPD_MUL2;
					pend_d = 1'b1;
				end else if (pend_q && sts.mac_done) begin
					pend_d  = 1'b0;
					state_d = S_SPD_MUL3;
				end
			end
			S_SPD_MUL3: begin
				if (can_go) begin
					cmd.op = OP_SPD_MUL3;
					pend_d = 1'b1;
				end else if (pend_q && sts.mac_done) begin
					pend_d  = 1'b0;
					state_d = S_SPD_DIV;
				end
			end
			S_SPD_DIV: begin
				if (can_go) begin
					cmd.op = OP_SPD_DIV;
					pend_d = 1'b1;
				end else if (pend_q && sts.div_done) begin
					pend_d       = 1'b0;
					cmd.op       = OP_SPD_SAVE;
					cmd.last_upd = 1'b1;
					state_d      = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				pend_d  = 1'b0;
			end
		endcase
	end

endmodule

@@ rtl/core/encoder_angle_speed_current_sense_top.sv @@
// Encoder electrical angle and speed estimator with phase current scaling (top level).
// One item at a time. No encoder or a failed counter read skips angle and speed,
// a first read or zero elapsed ticks skips speed. The 56-step angle division and
// the 32-step speed division share the single divider; s_tready rises again
// together with m_tvalid. Reset (arst_n, asynchronous) restores register defaults
// and clears the last sample and all held outputs.
module encoder_angle_speed_current_sense_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port: index selects the register, data is right-aligned.
	input  logic                           cfg_we,
	input  logic [easc_pkg::CFG_IX_W-1:0]   cfg_index,
	input  logic [easc_pkg::CFG_W-1:0]      cfg_data,
	// Input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// adc_raw [11:0], encoder_count [43:12], timestamp [107:44], zero pad [111:108]
	input  logic [easc_pkg::S_DATA_W-1:0]   s_tdata,
	// count_ok [0]
	input  logic                           s_tuser,
	// Result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// phase_current [31:0], elec_angle [47:32], elec_speed [79:48]
	output logic [easc_pkg::M_DATA_W-1:0]   m_tdata,
	// angle_valid [0], speed_valid [1]
	output logic [1:0]                     m_tuser
);
	import easc_pkg::*;

	// The controller and the datapath talk only through these two structs.
	cmd_t cmd;
	sts_t sts;

	// The controller walks each item through the current scaling (multiply, then
	// a rounded division by 40960 done as a 13-bit shift and a multiply by the
	// reciprocal of five), the angle (count times pole pairs, then one
	// division by the counts per revolution whose low 16 quotient bits are the
	// angle fraction) and the speed (denominator product, three numerator
	// products, then a 32-step division whose top bit flags saturation).
	easc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, the previous good sample, the held
	// angle and speed, the shared units and an output register, so a finished
	// item waits there while the next one is already being accepted.
	easc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTH
	// A result must never overwrite one that is still waiting to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output register loaded while holding an untaken item");

	// The shared units are launched only when both are idle.
	a_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CUR_MUL || cmd.op == OP_ANG_MUL || cmd.op == OP_DEN_MUL ||
		 cmd.op == OP_SPD_MUL1 || cmd.op == OP_SPD_MUL2 || cmd.op == OP_SPD_MUL3 ||
		 cmd.op == OP_CUR_DIV || cmd.op == OP_ANG_DIV || cmd.op == OP_SPD_DIV)
		|-> !sts.busy)
		else $error("shared unit started while busy");

	// A valid speed always comes with a valid angle.
	a_speed_needs_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tuser[0])
		else $error("speed valid without angle valid");

	// Only one item is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted again before the item finished");
`endif

endmodule
